// ----- sv/msadpcm_pkg.sv -----
`default_nettype none
package msadpcm_pkg;

  // Default number of usable predictor coefficient sets.
  localparam int NUM_COEF_SETS_DEF = 7;

  // Command queue between the byte front end and the decode back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Layout codes.
  localparam logic [1:0] LAYOUT_STD    = 2'd0;
  localparam logic [1:0] LAYOUT_REV    = 2'd1;
  localparam logic [1:0] LAYOUT_STEREO = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_ROUNDING = 1'b0;
  localparam logic CFG_LAYOUT   = 1'b1;

  // Header lengths in bytes.
  localparam logic [3:0] HLEN_MONO   = 4'd7;
  localparam logic [3:0] HLEN_STEREO = 4'd14;

  // Work handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_SET_COEF,
    OP_SET_DELTA,
    OP_SET_NEWER,
    OP_SET_OLDER,
    OP_DECODE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        ch;
    logic        emit;    // header is complete after this write
    logic        stereo;
    logic        rev;
    logic [15:0] value;   // coefficient index, 16-bit header field or data byte
  } cmd_t;

  typedef enum logic {
    BK_CMD,
    BK_EMIT
  } back_state_e;

  // First predictor coefficient of a set.
  function automatic logic signed [10:0] coef_first(input logic [2:0] idx);
    logic signed [10:0] c;
    case (idx)
      3'd0:    c = 11'sd256;
      3'd1:    c = 11'sd512;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd192;
      3'd4:    c = 11'sd240;
      3'd5:    c = 11'sd460;
      3'd6:    c = 11'sd392;
      default: c = 11'sd256;
    endcase
    return c;
  endfunction

  // Second predictor coefficient of a set.
  function automatic logic signed [10:0] coef_second(input logic [2:0] idx);
    logic signed [10:0] c;
    case (idx)
      3'd0:    c = 11'sd0;
      3'd1:    c = -11'sd256;
      3'd2:    c = 11'sd0;
      3'd3:    c = 11'sd64;
      3'd4:    c = 11'sd0;
      3'd5:    c = -11'sd208;
      3'd6:    c = -11'sd232;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  // Step size adaption factor per code, in units of 1/256.
  function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
    logic [9:0] a;
    case (nib)
      4'd4:    a = 10'd307;
      4'd5:    a = 10'd409;
      4'd6:    a = 10'd512;
      4'd7:    a = 10'd614;
      4'd8:    a = 10'd768;
      4'd9:    a = 10'd614;
      4'd10:   a = 10'd512;
      4'd11:   a = 10'd409;
      4'd12:   a = 10'd307;
      default: a = 10'd230;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- sv/msadpcm_front.sv -----
`default_nettype none
module msadpcm_front
  import msadpcm_pkg::*;
#(
  parameter int NUM_COEF_SETS = NUM_COEF_SETS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       block_start_i,
  input  wire logic [1:0] layout_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output cmd_t            q_cmd_o
);

  logic [3:0] hdr_pos_q, hdr_pos_d;
  logic [7:0] pend_q;

  logic       accept;
  logic       stereo, rev;
  logic [3:0] pos, pos_next, hlen, qoff;
  logic [2:0] fld;
  logic [2:0] coef_idx;
  logic       is_hdr, has_cmd, take_low;
  cmd_t       cmd;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // Classify the word against the header layout of the current mode.
  always_comb begin
    stereo   = (layout_i == LAYOUT_STEREO);
    rev      = (layout_i == LAYOUT_REV);
    hlen     = stereo ? HLEN_STEREO : HLEN_MONO;
    pos      = block_start_i ? 4'd0 : hdr_pos_q;
    pos_next = pos + 4'd1;
    qoff     = pos - 4'd2;
    fld      = qoff[3:1];
    coef_idx = (data_byte_i >= 8'(NUM_COEF_SETS)) ? 3'd0 : data_byte_i[2:0];
    is_hdr   = (pos < hlen);
    has_cmd  = 1'b1;
    take_low = 1'b0;

    cmd        = '0;
    cmd.op     = OP_DECODE;
    cmd.stereo = stereo;
    cmd.rev    = rev;
    cmd.value  = {8'h00, data_byte_i};

    if (is_hdr) begin
      cmd.emit = (pos_next == hlen);
      if (stereo) begin
        if (pos < 4'd2) begin
          cmd.op    = OP_SET_COEF;
          cmd.ch    = pos[0];
          cmd.value = {13'd0, coef_idx};
        end else begin
          cmd.ch = fld[0];
          if (!qoff[0]) begin
            has_cmd  = 1'b0;
            take_low = 1'b1;
          end else begin
            cmd.value = {data_byte_i, pend_q};
            if (fld < 3'd2) begin
              cmd.op = OP_SET_DELTA;
            end else if (fld < 3'd4) begin
              cmd.op = OP_SET_NEWER;
            end else begin
              cmd.op = OP_SET_OLDER;
            end
          end
        end
      end else begin
        if (pos == 4'd0) begin
          cmd.op    = OP_SET_COEF;
          cmd.value = {13'd0, coef_idx};
        end else if (pos[0]) begin
          has_cmd  = 1'b0;
          take_low = 1'b1;
        end else begin
          cmd.value = {data_byte_i, pend_q};
          if (pos == 4'd2) begin
            cmd.op = OP_SET_DELTA;
          end else if ((pos == 4'd4) != rev) begin
            cmd.op = OP_SET_NEWER;
          end else begin
            cmd.op = OP_SET_OLDER;
          end
        end
      end
    end

    hdr_pos_d = is_hdr ? pos_next : pos;
  end

  assign q_push_o = accept && has_cmd;
  assign q_cmd_o  = cmd;

  // Header position and the pending low byte of a 16-bit field.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= '0;
      pend_q    <= '0;
    end else if (accept) begin
      hdr_pos_q <= hdr_pos_d;
      if (take_low) begin
        pend_q <= data_byte_i;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/msadpcm_queue.sv -----
`default_nettype none
module msadpcm_queue
  import msadpcm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire cmd_t              cmd_i,
  input  wire logic              pop_i,
  output logic                   full_o,
  output logic                   vld_o,
  output cmd_t                   head_o,
  output logic [QCNT_W-1:0]      count_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/msadpcm_back.sv -----
`default_nettype none
module msadpcm_back
  import msadpcm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rounding_i,
  input  wire logic               head_vld_i,
  input  wire cmd_t               head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      sample_o,
  output logic                    channel_o,
  output logic                    last_o
);

  // Per-channel decoder state.
  logic signed [15:0] newer_q [2];
  logic signed [15:0] older_q [2];
  logic signed [31:0] delta_q [2];
  logic signed [10:0] c1_q    [2];
  logic signed [10:0] c2_q    [2];

  back_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        em_stereo_q, em_stereo_d;

  logic               out_vld_q;
  logic signed [15:0] sample_q;
  logic               chan_q, last_q;

  logic               ld_ok, do_dec, do_wr, load_out;
  logic               dch, em_ch, em_newer, em_last, sel_ch, use_hi;
  logic [3:0]         nib;
  logic signed [3:0]  code;
  logic signed [15:0] hn, ho, s_new, em_sample, out_sample;
  logic signed [31:0] dl, d_new;
  logic signed [10:0] k1, k2, adf;
  logic signed [27:0] pa, pb, psum, pscl;
  logic signed [36:0] cd, ssum;
  logic signed [42:0] ad, dscl;
  logic               out_chan, out_last;

  assign ld_ok = !out_vld_q || !out_stall_i;

  // Header sample emission order: older before newer, left before right.
  always_comb begin
    em_ch    = em_stereo_q ? step_q[0] : 1'b0;
    em_newer = em_stereo_q ? step_q[1] : step_q[0];
    em_last  = em_stereo_q ? (step_q == 2'd3) : (step_q == 2'd1);
    dch      = head_i.stereo ? step_q[0] : 1'b0;
    sel_ch   = (state_q == BK_EMIT) ? em_ch : dch;
    use_hi   = (head_i.stereo || !head_i.rev) ^ step_q[0];
    nib      = use_hi ? head_i.value[7:4] : head_i.value[3:0];
    code     = signed'(nib);
  end

  assign hn = newer_q[sel_ch];
  assign ho = older_q[sel_ch];
  assign dl = delta_q[sel_ch];
  assign k1 = c1_q[sel_ch];
  assign k2 = c2_q[sel_ch];
  assign em_sample = em_newer ? hn : ho;

  // One nibble: two-tap prediction, step scaling and delta adaption.
  always_comb begin
    pa   = 28'(hn) * 28'(k1);
    pb   = 28'(ho) * 28'(k2);
    psum = pa + pb;
    pscl = (psum + ((rounding_i && psum[27]) ? 28'sd255 : 28'sd0)) >>> 8;
    cd   = 37'(code) * 37'(dl);
    ssum = 37'(pscl) + cd;
    if (ssum > 37'sd32767) begin
      s_new = 16'sh7fff;
    end else if (ssum < -37'sd32768) begin
      s_new = 16'sh8000;
    end else begin
      s_new = ssum[15:0];
    end

    adf  = signed'({1'b0, adapt_factor(nib)});
    ad   = 43'(adf) * 43'(dl);
    dscl = (ad + ((rounding_i && ad[42]) ? 43'sd255 : 43'sd0)) >>> 8;
    if (dscl < 43'sd16) begin
      d_new = 32'sd16;
    end else if (dscl > 43'sd2147483647) begin
      d_new = 32'sh7fffffff;
    end else begin
      d_new = dscl[31:0];
    end
  end

  // Sequencer over queued commands and header sample emission.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    em_stereo_d = em_stereo_q;
    pop_o       = 1'b0;
    do_dec      = 1'b0;
    do_wr       = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      BK_CMD: begin
        if (head_vld_i) begin
          if (head_i.op == OP_DECODE) begin
            if (ld_ok) begin
              do_dec   = 1'b1;
              load_out = 1'b1;
              if (step_q[0]) begin
                pop_o  = 1'b1;
                step_d = 2'd0;
              end else begin
                step_d = 2'd1;
              end
            end
          end else begin
            do_wr = 1'b1;
            pop_o = 1'b1;
            if (head_i.emit) begin
              state_d     = BK_EMIT;
              step_d      = 2'd0;
              em_stereo_d = head_i.stereo;
            end
          end
        end
      end
      BK_EMIT: begin
        if (ld_ok) begin
          load_out = 1'b1;
          if (em_last) begin
            state_d = BK_CMD;
            step_d  = 2'd0;
          end else begin
            step_d = step_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = BK_CMD;
        step_d  = 2'd0;
      end
    endcase
  end

  always_comb begin
    if (state_q == BK_EMIT) begin
      out_sample = em_sample;
      out_chan   = em_ch;
      out_last   = em_last;
    end else begin
      out_sample = s_new;
      out_chan   = dch;
      out_last   = step_q[0];
    end
  end

  // Sequencer registers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CMD;
      step_q      <= '0;
      em_stereo_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      em_stereo_q <= em_stereo_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sample_q <= out_sample;
      chan_q   <= out_chan;
      last_q   <= out_last;
    end
  end

  // Channel state: header field writes and per-nibble updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        newer_q[i] <= '0;
        older_q[i] <= '0;
        delta_q[i] <= '0;
        c1_q[i]    <= '0;
        c2_q[i]    <= '0;
      end
    end else if (do_dec) begin
      older_q[dch] <= hn;
      newer_q[dch] <= s_new;
      delta_q[dch] <= d_new;
    end else if (do_wr) begin
      case (head_i.op)
        OP_SET_COEF: begin
          c1_q[head_i.ch] <= coef_first(head_i.value[2:0]);
          c2_q[head_i.ch] <= coef_second(head_i.value[2:0]);
        end
        OP_SET_DELTA: delta_q[head_i.ch] <= 32'(signed'(head_i.value));
        OP_SET_NEWER: newer_q[head_i.ch] <= signed'(head_i.value);
        OP_SET_OLDER: older_q[head_i.ch] <= signed'(head_i.value);
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign sample_o    = sample_q;
  assign channel_o   = chan_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ----- sv/ms_adpcm_block_decoder_top.sv -----
`default_nettype none
// Channel   Direction  Handshake                 Word
// input     in         in_valid_i / in_stall_o   data_byte_i, block_start_i
// output    out        out_valid_o / out_stall_i sample_o, channel_o, last_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The back end decodes a data byte one nibble at a time, since each
// nibble runs through the single prediction and adaption datapath.
// After the final header byte, the back end emits the header samples, two
// (mono) or four (stereo), one per output word.
// Reset clears all state but the queue entries and the output word; no
// clearing pass is needed. A four-entry command queue lets the byte side
// run ahead while the output stalls; input stalls only when it is full.
module ms_adpcm_block_decoder_top
  import msadpcm_pkg::*;
#(
  parameter int NUM_COEF_SETS = NUM_COEF_SETS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              block_start_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [15:0]     sample_o,
  output logic                   channel_o,
  output logic                   last_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [1:0]        cfg_data_i
);

  logic              rounding_q;
  logic [1:0]        layout_q;
  logic              q_push, q_pop, q_full, q_vld;
  cmd_t              q_cmd, q_head;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounding_q <= 1'b0;
      layout_q   <= LAYOUT_STD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROUNDING: rounding_q <= cfg_data_i[0];
        CFG_LAYOUT:   layout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  msadpcm_front #(
    .NUM_COEF_SETS(NUM_COEF_SETS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .block_start_i (block_start_i),
    .layout_i      (layout_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  msadpcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .vld_o   (q_vld),
    .head_o  (q_head),
    .count_o (q_count)
  );

  msadpcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rounding_i  (rounding_q),
    .head_vld_i  (q_vld),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .channel_o   (channel_o),
    .last_o      (last_o)
  );

  // The front end never writes into a full queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // The back end only retires a command that is present.
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_vld)
    else $error("command popped from an empty queue");

  // A push without a pop grows the queue by exactly one entry.
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("queue fill count out of step with pushes");

endmodule
`default_nettype wire
